// ===== src/lzw_decoder_top_defines.svh =====
// Assertion macros for the port checker of the LZW decoder.
`ifndef LZW_DECODER_TOP_DEFINES_SVH
`define LZW_DECODER_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LZWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property at every clock edge, reset included.
`define LZWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/lzwd_pkg.sv =====
// Shared types and constants of the LZW decoder.
`default_nettype none

package lzwd_pkg;

    localparam int ALPHABET_SIZE  = 256;
    localparam int DICT_DEPTH_DEF = 512;
    localparam int CODE_W         = 9;
    localparam int NFC_W          = 10;
    localparam int BYTE_W         = 8;
    localparam int STACK_DEPTH    = 257;
    localparam int SP_W           = 9;
    localparam int WORD_BYTES     = 8;
    localparam int LANE_W         = 4;
    localparam int WORD_W         = WORD_BYTES * BYTE_W;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              start_of_stream;
    } code_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LANE_W-1:0] byte_count;
        logic              last;
        logic              error;
    } text_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UNWIND,
        ST_EMIT,
        ST_ERROR
    } state_t;

    typedef enum logic [2:0] {
        CLS_START,
        CLS_START_BAD,
        CLS_STICKY,
        CLS_NORMAL,
        CLS_KWKWK,
        CLS_BAD
    } class_t;

    typedef struct packed {
        logic load_in;
        logic begin_start;
        logic begin_normal;
        logic begin_kwkwk;
        logic flag_error;
        logic unwind_step;
        logic commit;
        logic emit_run;
        logic emit_word;
        logic load_err;
    } cmd_t;

    typedef struct packed {
        class_t cls;
        logic   unwind_last;
        logic   word_ready;
        logic   final_word;
        logic   out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/lzwd_ctrl.sv =====
// Sequencing state machine of the LZW decoder.
`default_nettype none

module lzwd_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          code_valid,
    output logic               code_stall,
    input  lzwd_pkg::sts_t     sts,
    output lzwd_pkg::cmd_t     cmd
);

    lzwd_pkg::state_t state_reg;
    lzwd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzwd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                if (code_valid)
                begin
                    state_next = lzwd_pkg::ST_DECODE;
                end
            end
            lzwd_pkg::ST_DECODE:
            begin
                unique case (sts.cls) inside
                    lzwd_pkg::CLS_START:
                    begin
                        state_next = lzwd_pkg::ST_EMIT;
                    end
                    lzwd_pkg::CLS_NORMAL, lzwd_pkg::CLS_KWKWK:
                    begin
                        state_next = lzwd_pkg::ST_UNWIND;
                    end
                    default:
                    begin
                        state_next = lzwd_pkg::ST_ERROR;
                    end
                endcase
            end
            lzwd_pkg::ST_UNWIND:
            begin
                if (sts.unwind_last)
                begin
                    state_next = lzwd_pkg::ST_EMIT;
                end
            end
            lzwd_pkg::ST_EMIT:
            begin
                if (sts.word_ready && sts.out_free && sts.final_word)
                begin
                    state_next = lzwd_pkg::ST_IDLE;
                end
            end
            lzwd_pkg::ST_ERROR:
            begin
                if (sts.out_free)
                begin
                    state_next = lzwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        code_stall = 1'b1;
        unique case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                code_stall  = 1'b0;
                cmd.load_in = code_valid;
            end
            lzwd_pkg::ST_DECODE:
            begin
                unique case (sts.cls) inside
                    lzwd_pkg::CLS_START:
                    begin
                        cmd.begin_start = 1'b1;
                    end
                    lzwd_pkg::CLS_NORMAL:
                    begin
                        cmd.begin_normal = 1'b1;
                    end
                    lzwd_pkg::CLS_KWKWK:
                    begin
                        cmd.begin_kwkwk = 1'b1;
                    end
                    lzwd_pkg::CLS_START_BAD, lzwd_pkg::CLS_BAD:
                    begin
                        cmd.flag_error = 1'b1;
                    end
                    default:
                    begin
                        cmd.flag_error = 1'b0;
                    end
                endcase
            end
            lzwd_pkg::ST_UNWIND:
            begin
                cmd.unwind_step = 1'b1;
                cmd.commit      = sts.unwind_last;
            end
            lzwd_pkg::ST_EMIT:
            begin
                cmd.emit_run  = 1'b1;
                cmd.emit_word = sts.word_ready && sts.out_free;
            end
            lzwd_pkg::ST_ERROR:
            begin
                cmd.load_err = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lzwd_dp.sv =====
// Datapath of the LZW decoder: dictionary, unwind stack, packing and output register.
`default_nettype none

module lzwd_dp
#(
    parameter int DICT_DEPTH = lzwd_pkg::DICT_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  lzwd_pkg::code_item_t    code_item,
    output logic                    text_valid,
    input  wire logic               text_stall,
    output lzwd_pkg::text_item_t    text_item,
    input  lzwd_pkg::cmd_t          cmd,
    output lzwd_pkg::sts_t          sts
);

    localparam int ENTRY_DEPTH = DICT_DEPTH - lzwd_pkg::ALPHABET_SIZE;
    localparam int ENTRY_AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CODE_W      = lzwd_pkg::CODE_W;
    localparam int NFC_W       = lzwd_pkg::NFC_W;
    localparam int BYTE_W      = lzwd_pkg::BYTE_W;
    localparam int SP_W        = lzwd_pkg::SP_W;
    localparam int LANE_W      = lzwd_pkg::LANE_W;
    localparam int WORD_W      = lzwd_pkg::WORD_W;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] last_byte;
        logic [BYTE_W-1:0] first_byte;
    } entry_t;

    entry_t                dict_mem [0:ENTRY_DEPTH-1];
    entry_t                dict_rdata_reg;
    logic [ENTRY_AW-1:0]   dict_raddr;
    logic                  dict_we;

    logic [BYTE_W-1:0]     stack_mem [0:lzwd_pkg::STACK_DEPTH-1];
    logic [BYTE_W-1:0]     stack_rdata_reg;
    logic                  stack_we;
    logic [SP_W-1:0]       stack_waddr;
    logic [BYTE_W-1:0]     stack_wdata;

    logic [CODE_W-1:0]     code_reg,       code_next;
    logic                  start_reg,      start_next;
    logic [CODE_W-1:0]     prev_reg,       prev_next;
    logic [BYTE_W-1:0]     prev_first_reg, prev_first_next;
    logic [NFC_W-1:0]      nfc_reg,        nfc_next;
    logic                  sticky_reg,     sticky_next;
    logic [CODE_W-1:0]     c_reg,          c_next;
    logic [SP_W-1:0]       sp_reg,         sp_next;
    logic [BYTE_W-1:0]     first_reg,      first_next;
    logic                  first_pend_reg, first_pend_next;
    logic [LANE_W-1:0]     cnt_reg,        cnt_next;
    logic [LANE_W-1:0]     lane_reg,       lane_next;
    logic                  land_reg,       land_next;
    logic [WORD_W-1:0]     pack_reg,       pack_next;
    logic                  out_valid_reg,  out_valid_next;
    lzwd_pkg::text_item_t  out_item_reg,   out_item_next;

    logic                  code_is_dict;
    logic                  c_is_dict;
    logic                  push_entry;
    logic                  dict_room;
    logic                  issue;
    logic                  out_free;

    assign code_is_dict = code_reg >= CODE_W'(lzwd_pkg::ALPHABET_SIZE);
    assign c_is_dict    = c_reg >= CODE_W'(lzwd_pkg::ALPHABET_SIZE);
    assign push_entry   = c_is_dict && (sp_reg < SP_W'(lzwd_pkg::STACK_DEPTH - 1));
    assign dict_room    = nfc_reg < NFC_W'(DICT_DEPTH);
    assign issue        = cmd.emit_run && (sp_reg != '0)
                          && (cnt_reg != LANE_W'(lzwd_pkg::WORD_BYTES));
    assign out_free     = !out_valid_reg || !text_stall;
    assign dict_we      = cmd.commit && dict_room;

    always_comb
    begin
        if (start_reg)
        begin
            sts.cls = code_is_dict ? lzwd_pkg::CLS_START_BAD : lzwd_pkg::CLS_START;
        end
        else if (sticky_reg)
        begin
            sts.cls = lzwd_pkg::CLS_STICKY;
        end
        else if ({1'b0, code_reg} < nfc_reg)
        begin
            sts.cls = lzwd_pkg::CLS_NORMAL;
        end
        else if (({1'b0, code_reg} == nfc_reg) && dict_room)
        begin
            sts.cls = lzwd_pkg::CLS_KWKWK;
        end
        else
        begin
            sts.cls = lzwd_pkg::CLS_BAD;
        end
        sts.unwind_last = !push_entry;
        sts.word_ready  = ((cnt_reg == LANE_W'(lzwd_pkg::WORD_BYTES)) || (sp_reg == '0))
                          && !land_reg && (cnt_reg != '0);
        sts.final_word  = sp_reg == '0;
        sts.out_free    = out_free;
    end

    always_comb
    begin
        if (cmd.unwind_step)
        begin
            dict_raddr = dict_rdata_reg.prefix[ENTRY_AW-1:0];
        end
        else if (cmd.begin_kwkwk)
        begin
            dict_raddr = prev_reg[ENTRY_AW-1:0];
        end
        else
        begin
            dict_raddr = code_reg[ENTRY_AW-1:0];
        end
    end

    always_comb
    begin
        stack_we    = 1'b0;
        stack_waddr = sp_reg;
        stack_wdata = c_reg[BYTE_W-1:0];
        if (cmd.begin_start)
        begin
            stack_we    = 1'b1;
            stack_waddr = '0;
            stack_wdata = code_reg[BYTE_W-1:0];
        end
        else if (cmd.begin_kwkwk)
        begin
            stack_we    = 1'b1;
            stack_waddr = '0;
            stack_wdata = prev_first_reg;
        end
        else if (cmd.unwind_step)
        begin
            stack_we    = 1'b1;
            stack_wdata = push_entry ? dict_rdata_reg.last_byte : c_reg[BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[nfc_reg[ENTRY_AW-1:0]] <= '{prefix: prev_reg,
                                                 last_byte: first_reg,
                                                 first_byte: prev_first_reg};
        end
        dict_rdata_reg <= dict_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (issue)
        begin
            stack_rdata_reg <= stack_mem[sp_reg - SP_W'(1)];
        end
    end

    always_comb
    begin
        code_next       = code_reg;
        start_next      = start_reg;
        prev_next       = prev_reg;
        prev_first_next = prev_first_reg;
        nfc_next        = nfc_reg;
        sticky_next     = sticky_reg;
        c_next          = c_reg;
        sp_next         = sp_reg;
        first_next      = first_reg;
        first_pend_next = first_pend_reg;
        cnt_next        = cnt_reg;
        lane_next       = lane_reg;
        land_next       = issue;
        pack_next       = pack_reg;
        out_valid_next  = out_valid_reg && text_stall;
        out_item_next   = out_item_reg;

        if (cmd.load_in)
        begin
            code_next  = code_item.code;
            start_next = code_item.start_of_stream;
        end

        if (cmd.begin_start || cmd.begin_normal || cmd.begin_kwkwk)
        begin
            cnt_next  = '0;
            lane_next = '0;
            pack_next = '0;
        end

        if (cmd.begin_start)
        begin
            nfc_next        = NFC_W'(lzwd_pkg::ALPHABET_SIZE);
            sticky_next     = 1'b0;
            prev_next       = code_reg;
            prev_first_next = code_reg[BYTE_W-1:0];
            sp_next         = SP_W'(1);
        end

        if (cmd.begin_normal)
        begin
            c_next          = code_reg;
            sp_next         = '0;
            first_pend_next = code_is_dict;
            first_next      = code_reg[BYTE_W-1:0];
        end

        if (cmd.begin_kwkwk)
        begin
            c_next     = prev_reg;
            sp_next    = SP_W'(1);
            first_next = prev_first_reg;
        end

        if (cmd.flag_error)
        begin
            sticky_next = 1'b1;
            if (start_reg)
            begin
                nfc_next = NFC_W'(lzwd_pkg::ALPHABET_SIZE);
            end
        end

        if (cmd.unwind_step)
        begin
            sp_next = sp_reg + SP_W'(1);
            if (push_entry)
            begin
                c_next = dict_rdata_reg.prefix;
            end
            if (first_pend_reg)
            begin
                first_next      = dict_rdata_reg.first_byte;
                first_pend_next = 1'b0;
            end
        end

        if (cmd.commit)
        begin
            prev_next       = code_reg;
            prev_first_next = first_reg;
            if (dict_room)
            begin
                nfc_next = nfc_reg + NFC_W'(1);
            end
        end

        if (issue)
        begin
            sp_next  = sp_reg - SP_W'(1);
            cnt_next = cnt_reg + LANE_W'(1);
        end

        if (land_reg)
        begin
            pack_next[{lane_reg[2:0], 3'b000} +: BYTE_W] = stack_rdata_reg;
            lane_next = lane_reg + LANE_W'(1);
        end

        if (cmd.emit_word)
        begin
            out_valid_next           = 1'b1;
            out_item_next.bytes      = pack_reg;
            out_item_next.byte_count = lane_reg;
            out_item_next.last       = sp_reg == '0;
            out_item_next.error      = 1'b0;
            cnt_next                 = '0;
            lane_next                = '0;
            pack_next                = '0;
        end

        if (cmd.load_err)
        begin
            out_valid_next           = 1'b1;
            out_item_next.bytes      = '0;
            out_item_next.byte_count = '0;
            out_item_next.last       = 1'b1;
            out_item_next.error      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg       <= '0;
            start_reg      <= 1'b0;
            prev_reg       <= '0;
            prev_first_reg <= '0;
            nfc_reg        <= NFC_W'(lzwd_pkg::ALPHABET_SIZE);
            sticky_reg     <= 1'b0;
            c_reg          <= '0;
            sp_reg         <= '0;
            first_reg      <= '0;
            first_pend_reg <= 1'b0;
            cnt_reg        <= '0;
            lane_reg       <= '0;
            land_reg       <= 1'b0;
            pack_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            code_reg       <= code_next;
            start_reg      <= start_next;
            prev_reg       <= prev_next;
            prev_first_reg <= prev_first_next;
            nfc_reg        <= nfc_next;
            sticky_reg     <= sticky_next;
            c_reg          <= c_next;
            sp_reg         <= sp_next;
            first_reg      <= first_next;
            first_pend_reg <= first_pend_next;
            cnt_reg        <= cnt_next;
            lane_reg       <= lane_next;
            land_reg       <= land_next;
            pack_reg       <= pack_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    assign text_valid = out_valid_reg;
    assign text_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== src/lzw_decoder_top.sv =====
// LZW decoder over an 8-bit alphabet.
// Input channel code_*: one item per code word, with start_of_stream marking the
// first code of a stream. The item is taken only while the block is idle; code_stall
// stays high from acceptance until the last result of that code has entered the
// output register.
// Output channel text_*: the decoded string of each code, up to eight bytes per
// item, earliest byte in bits 7:0, last set on the final item of the code. An
// invalid code gives one error item; the error then holds until the next start.
// From acceptance until its last result enters the output register, a code passes a
// decode step, one dictionary read per cycle while its prefix chain is walked onto the
// unwind stack, one stack read per cycle while the bytes are packed and the word is not
// yet full, and per output item a step to land the last byte and one to hand the word
// over. A start code skips the dictionary walk; an invalid code goes from the decode
// step to the error item.
// Reset clears the state machine, the output register and the stream state; the
// dictionary and stack memories are not cleared and need no clearing pass.
// While text_stall is high the output item holds; packing runs on until the next word
// is full, then holds. The next code item is taken the cycle after the last result
// enters the output register.
`default_nettype none

module lzw_decoder_top
#(
    parameter int DICT_DEPTH = lzwd_pkg::DICT_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               code_valid,
    output logic                    code_stall,
    input  lzwd_pkg::code_item_t    code_item,
    output logic                    text_valid,
    input  wire logic               text_stall,
    output lzwd_pkg::text_item_t    text_item
);

    lzwd_pkg::cmd_t cmd;
    lzwd_pkg::sts_t sts;

    lzwd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    lzwd_dp
    #(
        .DICT_DEPTH (DICT_DEPTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_item  (code_item),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

// ===== src/lzwd_chk.sv =====
// Port checker of the LZW decoder and its binding to the top level.
`default_nettype none

`include "lzw_decoder_top_defines.svh"

module lzwd_chk
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  code_valid,
    input wire logic                  code_stall,
    input lzwd_pkg::code_item_t       code_item,
    input wire logic                  text_valid,
    input wire logic                  text_stall,
    input lzwd_pkg::text_item_t       text_item
);

    `LZWD_ASSERT(a_text_hold, text_valid && text_stall |=> text_valid && $stable(text_item), "stalled text item changed")

    `LZWD_ASSERT(a_error_shape, text_valid && text_item.error |-> text_item.last && (text_item.byte_count == 4'd0) && (text_item.bytes == 64'd0), "malformed error item")

    `LZWD_ASSERT(a_count_rule, text_valid && !text_item.error |-> (text_item.byte_count != 4'd0) && (text_item.byte_count <= 4'd8) && (text_item.last || (text_item.byte_count == 4'd8)), "bad byte count on text item")

    `LZWD_ASSERT(a_code_hold, code_valid && code_stall |=> $stable(code_item), "stalled code item changed")

    `LZWD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !text_valid, "text item shown after reset")

endmodule

bind lzw_decoder_top lzwd_chk u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item)
);

`default_nettype wire

// ===== verif/tb_lzw_decoder_top.sv =====
// Self-checking testbench of the LZW decoder: directed code table, a dictionary-filling stream, then random streams.
`timescale 1ns / 1ps

module tb_lzw_decoder_top;

    import lzwd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          OPENING_ROWS = 25;
    localparam text_item_t  ERROR_TEXT   = {64'd0, 4'd0, 1'b1, 1'b1};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              sos;
        logic              typed;
        logic [WORD_W-1:0] bytes;
        logic [LANE_W-1:0] count;
        logic              err;
    } code_row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        code_valid  = 1'b0;
    logic        code_stall;
    code_item_t  code_item   = '0;
    logic        text_valid;
    logic        text_stall  = 1'b0;
    text_item_t  text_item;

    logic [CODE_W-1:0] dict_prefix [0:255];
    logic [BYTE_W-1:0] dict_last   [0:255];
    logic [BYTE_W-1:0] dict_first  [0:255];
    logic [CODE_W-1:0] prev_code   = '0;
    logic [NFC_W-1:0]  free_code   = NFC_W'(ALPHABET_SIZE);
    bit                stream_bad  = 1'b0;

    text_item_t  pending_text [$];
    int          fail_count   = 0;
    int unsigned cycle_count  = 0;
    bit          quiet        = 1'b0;

    code_row_t opening_rows [0:OPENING_ROWS-1] = '{
        '{9'd65,  1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd256, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd0,   1'b1, 1'b1, 64'h00, 4'd1, 1'b0},
        '{9'd255, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd256, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd258, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd259, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd260, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd261, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd262, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd263, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd264, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd265, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd300, 1'b0, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd5,   1'b0, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd511, 1'b1, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd0,   1'b0, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd255, 1'b1, 1'b1, 64'hff, 4'd1, 1'b0},
        '{9'd511, 1'b0, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd128, 1'b1, 1'b1, 64'h80, 4'd1, 1'b0},
        '{9'd256, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd257, 1'b0, 1'b0, 64'h0,  4'd0, 1'b0},
        '{9'd256, 1'b1, 1'b1, 64'h0,  4'd0, 1'b1},
        '{9'd1,   1'b1, 1'b1, 64'h01, 4'd1, 1'b0},
        '{9'd1,   1'b0, 1'b0, 64'h0,  4'd0, 1'b0}
    };

    lzw_decoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL lzw_decoder_top");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] first_of(input logic [CODE_W-1:0] c);
        return (c < ALPHABET_SIZE) ? c[7:0] : dict_first[c[7:0]];
    endfunction

    function automatic void unwind_onto(input logic [CODE_W-1:0] c,
                                        ref logic [BYTE_W-1:0] text_q[$]);
        logic [CODE_W-1:0] walk;
        walk = c;
        while (walk >= ALPHABET_SIZE && text_q.size() < STACK_DEPTH - 1)
        begin
            text_q.push_front(dict_last[walk[7:0]]);
            walk = dict_prefix[walk[7:0]];
        end
        if (text_q.size() < STACK_DEPTH)
            text_q.push_front(walk[7:0]);
    endfunction

    function automatic void decode_text(input code_item_t it, ref text_item_t res[$]);
        logic [BYTE_W-1:0] text_q [$];
        logic [BYTE_W-1:0] head;
        text_item_t        word;
        int                k;
        res = {};
        if (it.start_of_stream)
        begin
            free_code  = NFC_W'(ALPHABET_SIZE);
            stream_bad = 1'b0;
            if (it.code >= ALPHABET_SIZE)
            begin
                stream_bad = 1'b1;
                res = {res, ERROR_TEXT};
                return;
            end
            prev_code = it.code;
            text_q = {text_q, it.code[7:0]};
        end
        else if (stream_bad)
        begin
            res = {res, ERROR_TEXT};
            return;
        end
        else
        begin
            if (it.code < free_code)
            begin
                unwind_onto(it.code, text_q);
                head = first_of(it.code);
            end
            else if (it.code == free_code && free_code < DICT_DEPTH_DEF)
            begin
                head = first_of(prev_code);
                text_q = {text_q, head};
                unwind_onto(prev_code, text_q);
            end
            else
            begin
                stream_bad = 1'b1;
                res = {res, ERROR_TEXT};
                return;
            end
            if (free_code < DICT_DEPTH_DEF)
            begin
                dict_prefix[free_code[7:0]] = prev_code;
                dict_last[free_code[7:0]]   = head;
                dict_first[free_code[7:0]]  = first_of(prev_code);
                free_code = free_code + 1'b1;
            end
            prev_code = it.code;
        end
        while (text_q.size() > 0)
        begin
            word = '0;
            for (k = 0; k < WORD_BYTES && text_q.size() > 0; k++)
                word.bytes[8*k +: 8] = text_q.pop_front();
            word.byte_count = LANE_W'(k);
            word.last       = (text_q.size() == 0);
            res = {res, word};
        end
    endfunction

    task automatic send_code(input code_item_t it, input bit typed, input text_item_t typed_text);
        text_item_t outcome [$];
        while (!quiet && $urandom_range(99) < 19)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code_valid <= 1'b1;
        code_item  <= it;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        decode_text(it, outcome);
        if (typed)
            pending_text = {pending_text, typed_text};
        else
            foreach (outcome[i])
                pending_text = {pending_text, outcome[i]};
    endtask

    always @(posedge clk)
    begin : check_text
        text_item_t want;
        if (rst_n && text_valid && !text_stall)
        begin
            if (pending_text.size() == 0)
            begin
                $error("text item with nothing pending: %h", text_item);
                fail_count++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (text_item.bytes !== want.bytes)
                begin
                    $error("bytes: expected %h, got %h", want.bytes, text_item.bytes);
                    fail_count++;
                end
                if (text_item.byte_count !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d",
                           want.byte_count, text_item.byte_count);
                    fail_count++;
                end
                if (text_item.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, text_item.last);
                    fail_count++;
                end
                if (text_item.error !== want.error)
                begin
                    $error("error: expected %b, got %b", want.error, text_item.error);
                    fail_count++;
                end
            end
        end
        text_stall <= rst_n && !quiet && ($urandom_range(99) < 19);
    end

    initial
    begin : stimulus
        code_item_t it;
        code_row_t  row;
        int         n;
        int         roll;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < OPENING_ROWS; n++)
        begin
            row = opening_rows[n];
            it.code            = row.code;
            it.start_of_stream = row.sos;
            send_code(it, row.typed, {row.bytes, row.count, 1'b1, row.err});
        end

        // grow one string per code until the dictionary is full, then decode at random
        it.start_of_stream = 1'b1;
        it.code            = CODE_W'($urandom_range(255));
        send_code(it, 1'b0, '0);
        it.start_of_stream = 1'b0;
        for (n = 0; n < 256; n++)
        begin
            it.code = free_code[CODE_W-1:0];
            send_code(it, 1'b0, '0);
        end
        for (n = 0; n < 20; n++)
        begin
            it.code = CODE_W'($urandom_range(511));
            send_code(it, 1'b0, '0);
        end

        code_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        for (n = 0; n < 170; n++)
        begin
            quiet = (n >= 60 && n < 110);
            roll  = $urandom_range(99);
            if (stream_bad ? roll < 70 : roll < 4)
            begin
                it.start_of_stream = 1'b1;
                if ($urandom_range(9) == 0)
                    it.code = CODE_W'($urandom_range(511, 256));
                else
                    it.code = CODE_W'($urandom_range(255));
            end
            else
            begin
                it.start_of_stream = 1'b0;
                if (roll < 7 && free_code < 511)
                    it.code = CODE_W'($urandom_range(511, free_code + 1));
                else if (roll < 22 && free_code < DICT_DEPTH_DEF)
                    it.code = free_code[CODE_W-1:0];
                else
                    it.code = CODE_W'($urandom_range(free_code - 1));
            end
            send_code(it, 1'b0, '0);
        end
        quiet = 1'b0;

        code_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS lzw_decoder_top");
        else
            $display("FAIL lzw_decoder_top");
        $finish;
    end

endmodule
